/* hdl/abf_pkg.sv */
// Shared types and constants of the accumulation buffer with bilinear sampling.
package abf_pkg;

	localparam int DEF_MAX_WIDTH    = 256;
	localparam int DEF_MAX_HEIGHT   = 256;
	localparam int DEF_CHANNEL_BITS = 32;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_SET    = 3'd1;
	localparam logic [2:0] OP_ADD    = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_SAMPLE = 3'd4;

	localparam logic [1:0] CFG_H_RES      = 2'd0;
	localparam logic [1:0] CFG_V_RES      = 2'd1;
	localparam logic [1:0] CFG_ADD_FACTOR = 2'd2;

	localparam logic [8:0]  RST_H_RES      = 9'd256;
	localparam logic [8:0]  RST_V_RES      = 9'd256;
	localparam logic [15:0] RST_ADD_FACTOR = 16'd256;

	localparam logic [7:0] HALF_PIXEL = 8'd128;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [7:0]  frac_x;
		logic [7:0]  frac_y;
		logic [31:0] in_red;
		logic [31:0] in_green;
		logic [31:0] in_blue;
	} cmd_t;

	typedef struct packed {
		logic [31:0] out_red;
		logic [31:0] out_green;
		logic [31:0] out_blue;
		logic        saturated;
	} rsp_t;

endpackage

/* hdl/accumulation_buffer_bilinear_top.sv */
// Top level of the accumulation buffer with bilinear sampling.
//
// An item is taken when start is high and busy is low; its one result appears on rsp for a
// single cycle with strobe high and cannot be held off. All channel products run through one
// shared 32x17 multiplier and one adder into three channel accumulators, and the pixel store
// is a single-port RAM with registered read, so an item's latency is set by memory reads and
// multiplier passes: read takes one read, set and add one read and three products, bilinear
// sample four reads and twelve products, clear a write to every pixel; an undefined operation
// goes straight to the result. After reset the block sweeps the store to zero with busy high;
// configuration writes are taken meanwhile.
module accumulation_buffer_bilinear_top
	import abf_pkg::*;
#(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        strobe,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int HWB   = $clog2(MAX_WIDTH + 1);
	localparam int VWB   = $clog2(MAX_HEIGHT + 1);
	localparam int HB    = (HWB > VWB) ? HWB : VWB;
	localparam int EW    = (HB > 9) ? HB : 9;
	localparam int CB    = CHANNEL_BITS;
	localparam int PW    = 49;
	localparam int ACCW  = 50;
	localparam logic [ACCW-1:0] CHAN_MAX = ACCW'((64'd1 << CB) - 64'd1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_WAIT = 4'd3;
	localparam logic [3:0] S_MUL  = 4'd4;
	localparam logic [3:0] S_ACC  = 4'd5;
	localparam logic [3:0] S_FIN  = 4'd6;

	logic [3:0]        state_q;
	logic              init_q;
	logic [AW-1:0]     cursor_q;
	logic [8:0]        h_res_q;
	logic [8:0]        v_res_q;
	logic [15:0]       add_factor_q;
	logic [2:0]        op_q;
	logic [EW-1:0]     c_q, c1_q, r_q, r1_q;
	logic [7:0]        u_q, w_q;
	logic [31:0]       in_q [3];
	logic [1:0]        n_q;
	logic [1:0]        j_q;
	logic [16:0]       wgt_q;
	logic [3*CB-1:0]   pix_q;
	logic [PW-1:0]     prod_q;
	logic [ACCW-1:0]   acc_q [3];
	logic              strobe_q;
	rsp_t              rsp_q;

	logic [EW-1:0]     h_ext, v_ext, h_eff, v_eff, hm1, vm1;
	logic [EW-1:0]     c_in, r_in, c_cl, r_cl, c_nb, r_nb;
	logic [7:0]        u_in, w_in;
	logic [EW-1:0]     col_sel, row_sel;
	logic [2*EW-1:0]   lin_addr;
	logic [AW-1:0]     addr_sel;
	logic [8:0]        colw, roww;
	logic [17:0]       wgt_full;
	logic [31:0]       mul_a;
	logic [16:0]       mul_b;
	logic [CB-1:0]     pix_ch;
	logic [ACCW-1:0]   sat_ch [3];
	logic [ACCW-1:0]   rnd_ch [3];
	logic [2:0]        sat_bit;
	logic [3*CB-1:0]   sat_data;
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [3*CB-1:0]   ram_wdata;
	logic [3*CB-1:0]   ram_rdata;
	rsp_t              fin_rsp;

	// effective resolution, clamped coordinates, neighbours and fractional offsets
	always_comb begin
		h_ext = EW'(h_res_q);
		v_ext = EW'(v_res_q);
		if (h_ext == '0) begin
			h_eff = EW'(1);
		end else if (h_ext > EW'(MAX_WIDTH)) begin
			h_eff = EW'(MAX_WIDTH);
		end else begin
			h_eff = h_ext;
		end
		if (v_ext == '0) begin
			v_eff = EW'(1);
		end else if (v_ext > EW'(MAX_HEIGHT)) begin
			v_eff = EW'(MAX_HEIGHT);
		end else begin
			v_eff = v_ext;
		end
		hm1  = h_eff - EW'(1);
		vm1  = v_eff - EW'(1);
		c_in = EW'(cmd.col);
		r_in = EW'(cmd.row);
		c_cl = (c_in > hm1) ? hm1 : c_in;
		r_cl = (r_in > vm1) ? vm1 : r_in;
		if (cmd.frac_x < HALF_PIXEL) begin
			u_in = HALF_PIXEL - cmd.frac_x;
			c_nb = (c_cl != '0) ? c_cl - EW'(1) : '0;
		end else begin
			u_in = cmd.frac_x - HALF_PIXEL;
			c_nb = (c_cl + EW'(1) > hm1) ? hm1 : c_cl + EW'(1);
		end
		if (cmd.frac_y < HALF_PIXEL) begin
			w_in = HALF_PIXEL - cmd.frac_y;
			r_nb = (r_cl != '0) ? r_cl - EW'(1) : '0;
		end else begin
			w_in = cmd.frac_y - HALF_PIXEL;
			r_nb = (r_cl + EW'(1) > vm1) ? vm1 : r_cl + EW'(1);
		end
	end

	// neighbour address and weight
	always_comb begin
		col_sel  = (n_q == 2'd1 || n_q == 2'd2) ? c1_q : c_q;
		row_sel  = n_q[1] ? r1_q : r_q;
		lin_addr = (2*EW)'(vm1 - row_sel) * (2*EW)'(h_eff) + (2*EW)'(col_sel);
		addr_sel = AW'(lin_addr);
		colw     = (n_q == 2'd1 || n_q == 2'd2) ? {1'b0, u_q} : 9'd256 - {1'b0, u_q};
		roww     = n_q[1] ? {1'b0, w_q} : 9'd256 - {1'b0, w_q};
		wgt_full = 18'(colw) * 18'(roww);
	end

	// shared multiplier operands
	always_comb begin
		pix_ch = pix_q[j_q*CB +: CB];
		if (op_q == OP_SAMPLE) begin
			mul_a = 32'(pix_ch);
			mul_b = wgt_q;
		end else begin
			case (j_q)
				2'd0:    mul_a = in_q[0];
				2'd1:    mul_a = in_q[1];
				default: mul_a = in_q[2];
			endcase
			mul_b = {1'b0, add_factor_q};
		end
	end

	// final rounding and saturation
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sat_bit[k] = acc_q[k] > CHAN_MAX;
			sat_ch[k]  = sat_bit[k] ? CHAN_MAX : acc_q[k];
			rnd_ch[k]  = (acc_q[k] + ACCW'(32768)) >> 16;
			sat_data[k*CB +: CB] = sat_ch[k][CB-1:0];
		end
		fin_rsp = '0;
		unique case (op_q) inside
			OP_SAMPLE: begin
				fin_rsp.out_red   = 32'(rnd_ch[0]);
				fin_rsp.out_green = 32'(rnd_ch[1]);
				fin_rsp.out_blue  = 32'(rnd_ch[2]);
			end
			OP_SET, OP_ADD: begin
				fin_rsp.out_red   = 32'(sat_ch[0]);
				fin_rsp.out_green = 32'(sat_ch[1]);
				fin_rsp.out_blue  = 32'(sat_ch[2]);
				fin_rsp.saturated = |sat_bit;
			end
			OP_READ: begin
				fin_rsp.out_red   = 32'(pix_q[0 +: CB]);
				fin_rsp.out_green = 32'(pix_q[CB +: CB]);
				fin_rsp.out_blue  = 32'(pix_q[2*CB +: CB]);
			end
			default: fin_rsp = '0;
		endcase
	end

	always_comb begin
		ram_we    = (state_q == S_CLR) ||
		            (state_q == S_FIN && (op_q == OP_SET || op_q == OP_ADD));
		ram_addr  = (state_q == S_CLR) ? cursor_q : addr_sel;
		ram_wdata = (state_q == S_CLR) ? '0 : sat_data;
	end

	abf_ram #(
		.WIDTH(3*CB),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_res_q      <= RST_H_RES;
			v_res_q      <= RST_V_RES;
			add_factor_q <= RST_ADD_FACTOR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_H_RES:      h_res_q      <= cfg_data[8:0];
				CFG_V_RES:      v_res_q      <= cfg_data[8:0];
				CFG_ADD_FACTOR: add_factor_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			init_q   <= 1'b1;
			cursor_q <= '0;
			n_q      <= '0;
			j_q      <= '0;
			strobe_q <= 1'b0;
			op_q     <= OP_CLEAR;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= cmd.operation;
						n_q      <= '0;
						j_q      <= '0;
						cursor_q <= '0;
						unique case (cmd.operation) inside
							OP_SET, OP_ADD, OP_READ, OP_SAMPLE: state_q <= S_RD;
							OP_CLEAR: state_q <= S_CLR;
							default:  state_q <= S_FIN;
						endcase
					end
				end
				S_CLR: begin
					cursor_q <= cursor_q + AW'(1);
					if (cursor_q == AW'(DEPTH - 1)) begin
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_FIN;
					end
				end
				S_RD: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					j_q     <= '0;
					state_q <= (op_q == OP_READ) ? S_FIN : S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					j_q <= j_q + 2'd1;
					if (j_q != 2'd2) begin
						state_q <= S_MUL;
					end else if (op_q == OP_SAMPLE && n_q != 2'd3) begin
						n_q     <= n_q + 2'd1;
						state_q <= S_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			c_q      <= c_cl;
			r_q      <= r_cl;
			c1_q     <= c_nb;
			r1_q     <= r_nb;
			u_q      <= u_in;
			w_q      <= w_in;
			in_q[0]  <= cmd.in_red;
			in_q[1]  <= cmd.in_green;
			in_q[2]  <= cmd.in_blue;
			acc_q[0] <= '0;
			acc_q[1] <= '0;
			acc_q[2] <= '0;
		end
		if (state_q == S_RD) begin
			wgt_q <= wgt_full[16:0];
		end
		if (state_q == S_WAIT) begin
			pix_q <= ram_rdata;
		end
		if (state_q == S_MUL) begin
			prod_q <= PW'(mul_a) * PW'(mul_b);
		end
		if (state_q == S_ACC) begin
			if (op_q == OP_SAMPLE) begin
				acc_q[j_q] <= acc_q[j_q] + ACCW'(prod_q);
			end else begin
				acc_q[j_q] <= ((ACCW'(prod_q) + ACCW'(128)) >> 8) +
				              ((op_q == OP_ADD) ? ACCW'(pix_ch) : '0);
			end
		end
		if (state_q == S_FIN) begin
			rsp_q <= fin_rsp;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign rsp    = rsp_q;

`ifndef NO_ASSERTIONS
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item taken but block not busy");
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result beat longer than one cycle");
	a_sat_only_write: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && rsp.saturated |-> (op_q == OP_SET || op_q == OP_ADD))
		else $error("saturation flagged on non-write operation");
	a_strobe_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q) == S_FIN)
		else $error("result beat without final step");
`endif

endmodule

/* hdl/abf_ram.sv */
// Generic single-port RAM with registered read.
module abf_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* test/accumulation_buffer_bilinear_top_tb.sv */
// Testbench for the accumulation buffer with bilinear sampling: predicts every result and checks it.
`timescale 1ns / 100ps

module accumulation_buffer_bilinear_top_tb;
	import abf_pkg::*;

	localparam int LIMIT = 400000;
	localparam int PIXELS = 65536;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	cmd_t        cmd = '0;
	logic        strobe;
	rsp_t        rsp;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	logic [31:0] frame_mem [PIXELS][3];
	logic [8:0]  h_reg;
	logic [8:0]  v_reg;
	logic [15:0] factor_reg;
	rsp_t        pending_pixels [$];
	int          errors = 0;
	int          idle_cycles = 0;
	bit          gaps_on = 1'b1;

	accumulation_buffer_bilinear_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.strobe(strobe), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned eff_size(logic [8:0] r);
		if (r == 0) return 1;
		return (r > 256) ? 256 : r;
	endfunction

	function automatic int unsigned pix_addr(int unsigned c, int unsigned r, int unsigned h,
			int unsigned v);
		int unsigned a;
		a = c + (v - 1 - r) * h;
		return (a < PIXELS) ? a : 0;
	endfunction

	function automatic rsp_t predict_pixel(cmd_t c);
		rsp_t        res;
		int unsigned h, v, cc, rr, c1, r1, u, w;
		int unsigned a00, a10, a11, a01;
		logic [63:0] s, acc, w00, w10, w11, w01;
		logic [31:0] x;
		res = '0;
		h = eff_size(h_reg);
		v = eff_size(v_reg);
		cc = (c.col > h - 1) ? h - 1 : c.col;
		rr = (c.row > v - 1) ? v - 1 : c.row;
		case (c.operation)
			OP_CLEAR: begin
				for (int i = 0; i < PIXELS; i++)
					for (int k = 0; k < 3; k++) frame_mem[i][k] = '0;
			end
			OP_SET, OP_ADD: begin
				a00 = pix_addr(cc, rr, h, v);
				for (int k = 0; k < 3; k++) begin
					x = (k == 0) ? c.in_red : (k == 1) ? c.in_green : c.in_blue;
					s = (64'(x) * 64'(factor_reg) + 64'd128) >> 8;
					if (c.operation == OP_ADD) s += 64'(frame_mem[a00][k]);
					if (s > 64'hFFFF_FFFF) begin
						s = 64'hFFFF_FFFF;
						res.saturated = 1'b1;
					end
					frame_mem[a00][k] = s[31:0];
					if (k == 0) res.out_red = s[31:0];
					else if (k == 1) res.out_green = s[31:0];
					else res.out_blue = s[31:0];
				end
			end
			OP_READ: begin
				a00 = pix_addr(cc, rr, h, v);
				res.out_red = frame_mem[a00][0];
				res.out_green = frame_mem[a00][1];
				res.out_blue = frame_mem[a00][2];
			end
			OP_SAMPLE: begin
				if (c.frac_x < HALF_PIXEL) begin
					u = HALF_PIXEL - c.frac_x;
					c1 = (cc > 0) ? cc - 1 : 0;
				end else begin
					u = c.frac_x - HALF_PIXEL;
					c1 = (cc + 1 > h - 1) ? h - 1 : cc + 1;
				end
				if (c.frac_y < HALF_PIXEL) begin
					w = HALF_PIXEL - c.frac_y;
					r1 = (rr > 0) ? rr - 1 : 0;
				end else begin
					w = c.frac_y - HALF_PIXEL;
					r1 = (rr + 1 > v - 1) ? v - 1 : rr + 1;
				end
				a00 = pix_addr(cc, rr, h, v);
				a10 = pix_addr(c1, rr, h, v);
				a11 = pix_addr(c1, r1, h, v);
				a01 = pix_addr(cc, r1, h, v);
				w00 = 64'((256 - u) * (256 - w));
				w10 = 64'(u * (256 - w));
				w11 = 64'(u * w);
				w01 = 64'((256 - u) * w);
				for (int k = 0; k < 3; k++) begin
					acc = 64'(frame_mem[a00][k]) * w00 + 64'(frame_mem[a10][k]) * w10
						+ 64'(frame_mem[a11][k]) * w11 + 64'(frame_mem[a01][k]) * w01;
					acc = (acc + 64'd32768) >> 16;
					if (k == 0) res.out_red = acc[31:0];
					else if (k == 1) res.out_green = acc[31:0];
					else res.out_blue = acc[31:0];
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk) begin
		rsp_t exp_pix;
		if (strobe) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected result beat %h", rsp);
				errors++;
			end else begin
				exp_pix = pending_pixels.pop_front();
				if (rsp.out_red !== exp_pix.out_red) begin
					$error("out_red exp %h got %h", exp_pix.out_red, rsp.out_red);
					errors++;
				end
				if (rsp.out_green !== exp_pix.out_green) begin
					$error("out_green exp %h got %h", exp_pix.out_green, rsp.out_green);
					errors++;
				end
				if (rsp.out_blue !== exp_pix.out_blue) begin
					$error("out_blue exp %h got %h", exp_pix.out_blue, rsp.out_blue);
					errors++;
				end
				if (rsp.saturated !== exp_pix.saturated) begin
					$error("saturated exp %b got %b", exp_pix.saturated, rsp.saturated);
					errors++;
				end
			end
		end
	end

	// Watchdog: count cycles with no beat accepted either way.
	always @(posedge clk) begin
		if (strobe || (start && !busy) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > LIMIT) begin
			$display("accumulation_buffer_bilinear_top_tb: FAIL");
			$finish;
		end
	end

	task automatic send_beat(cmd_t c);
		while (gaps_on && $urandom_range(99) < 36) @(posedge clk);
		cmd <= c;
		start <= 1'b1;
		@(posedge clk iff !busy);
		pending_pixels.push_back(predict_pixel(c));
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_H_RES) h_reg = val[8:0];
		else if (idx == CFG_V_RES) v_reg = val[8:0];
		else factor_reg = val;
		@(posedge clk);
	endtask

	function automatic cmd_t rand_cmd(logic [2:0] op, int unsigned cmax, int unsigned rmax);
		cmd_t c;
		c.operation = op;
		c.col = 8'($urandom_range(cmax));
		c.row = 8'($urandom_range(rmax));
		c.frac_x = 8'($urandom);
		c.frac_y = 8'($urandom);
		c.in_red = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0020_0000);
		c.in_green = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0020_0000);
		c.in_blue = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0020_0000);
		return c;
	endfunction

	task automatic test_directed();
		cmd_t c;
		c = '{OP_SET, 8'd0, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000};
		send_beat(c);
		c = '{OP_ADD, 8'd0, 8'd0, 8'd0, 8'd0, 32'h1, 32'h1, 32'h1};
		send_beat(c);
		c = '{OP_SET, 8'd255, 8'd255, 8'd0, 8'd0, 32'h1234_5678, 32'h8000_0000, 32'h7};
		send_beat(c);
		c = '{OP_SET, 8'd1, 8'd0, 8'd0, 8'd0, 32'h0003_0000, 32'h0005_0000, 32'h0};
		send_beat(c);
		c = '{OP_SET, 8'd0, 8'd1, 8'd0, 8'd0, 32'h0009_0000, 32'h0, 32'hFFFF};
		send_beat(c);
		c = '{OP_READ, 8'd255, 8'd255, 8'd0, 8'd0, 32'h0, 32'h0, 32'h0};
		send_beat(c);
		c = '{OP_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd0, 32'h0, 32'h0, 32'h0};
		send_beat(c);
		c = '{OP_SAMPLE, 8'd0, 8'd0, 8'd255, 8'd255, 32'h0, 32'h0, 32'h0};
		send_beat(c);
		c = '{OP_SAMPLE, 8'd0, 8'd0, 8'd128, 8'd128, 32'h0, 32'h0, 32'h0};
		send_beat(c);
		c = '{OP_SAMPLE, 8'd255, 8'd255, 8'd255, 8'd0, 32'h0, 32'h0, 32'h0};
		send_beat(c);
		for (int op = 5; op < 8; op++) begin
			c = '{3'(op), 8'd3, 8'd3, 8'd1, 8'd1, 32'hFFFF_FFFF, 32'h1, 32'h2};
			send_beat(c);
		end
		c = '{OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 32'h0, 32'h0, 32'h0};
		send_beat(c);
		c = '{OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 32'h0, 32'h0, 32'h0};
		send_beat(c);
		drain();
	endtask

	task automatic test_config_extremes();
		write_reg(CFG_ADD_FACTOR, 16'hFFFF);
		write_reg(CFG_H_RES, 16'd1);
		write_reg(CFG_V_RES, 16'd0);
		send_beat('{OP_SET, 8'd200, 8'd17, 8'd0, 8'd0, 32'hFFFF_FFFF, 32'h100, 32'h0});
		send_beat('{OP_SAMPLE, 8'd9, 8'd9, 8'd0, 8'd255, 32'h0, 32'h0, 32'h0});
		drain();
		write_reg(CFG_H_RES, 16'h01FF);
		write_reg(CFG_V_RES, 16'h0101);
		write_reg(CFG_ADD_FACTOR, 16'd0);
		send_beat('{OP_ADD, 8'd255, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 32'h1, 32'h1});
		send_beat('{OP_READ, 8'd0, 8'd255, 8'd0, 8'd0, 32'h0, 32'h0, 32'h0});
		drain();
	endtask

	task automatic test_random_phase(logic [8:0] h, logic [8:0] v, logic [15:0] f, int n);
		int unsigned cmax, rmax, pick;
		logic [2:0]  op;
		write_reg(CFG_H_RES, {7'd0, h});
		write_reg(CFG_V_RES, {7'd0, v});
		write_reg(CFG_ADD_FACTOR, f);
		cmax = (h > 8) ? 8 : 255;
		rmax = (v > 8) ? 8 : 255;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 25) op = OP_SET;
			else if (pick < 50) op = OP_ADD;
			else if (pick < 65) op = OP_READ;
			else if (pick < 95) op = OP_SAMPLE;
			else op = 3'($urandom_range(7, 5));
			send_beat(rand_cmd(op, ($urandom_range(9) == 0) ? 255 : cmax,
				($urandom_range(9) == 0) ? 255 : rmax));
		end
		drain();
	endtask

	task automatic test_random_clear();
		send_beat(rand_cmd(OP_CLEAR, 255, 255));
		send_beat(rand_cmd(OP_SAMPLE, 4, 4));
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		h_reg = RST_H_RES;
		v_reg = RST_V_RES;
		factor_reg = RST_ADD_FACTOR;
		for (int i = 0; i < PIXELS; i++)
			for (int k = 0; k < 3; k++) frame_mem[i][k] = '0;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random_phase(9'd5, 9'd4, 16'd256, 90);
		gaps_on = 1'b0;
		test_random_phase(9'd256, 9'd256, 16'd384, 90);
		gaps_on = 1'b1;
		test_random_phase(9'd1, 9'd7, 16'hFFFF, 80);
		test_random_clear();
		test_random_phase(9'd3, 9'd1, 16'd77, 80);
		test_random_phase(9'd300, 9'd2, 16'd256, 90);
		if (errors == 0) $display("accumulation_buffer_bilinear_top_tb: PASS");
		else $display("accumulation_buffer_bilinear_top_tb: FAIL");
		$finish;
	end

endmodule

/* sim.f */
hdl/abf_pkg.sv
hdl/abf_ram.sv
hdl/accumulation_buffer_bilinear_top.sv
test/accumulation_buffer_bilinear_top_tb.sv
